/* rtl/olc_pkg.sv */
// ----------------------------------------------------------------------------
// olc_pkg: shared types and helpers for the occupancy light controller
// Item, result, register and state layouts, reset values and the lamp
// helper functions used by the update logic.
// ----------------------------------------------------------------------------
package olc_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_DOOR   = 3'd1,
    OP_MOTION = 3'd2,
    OP_POLL   = 3'd3,
    OP_REMOTE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_ON       = 2'd0,
    CMD_OFF      = 2'd1,
    CMD_AUTO_EN  = 2'd2,
    CMD_AUTO_DIS = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ABSENCE_TIMEOUT = 3'd0,
    REG_TICKS_PER_SEC   = 3'd1,
    REG_MOTION_GRACE    = 3'd2,
    REG_DEBOUNCE        = 3'd3,
    REG_DARK            = 3'd4
  } reg_idx_e;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  typedef struct packed {
    logic [2:0] op;
    logic       door_level;
    logic       motion_level;
    logic       key_top_open;
    logic       key_side_open;
    logic       button_top_pressed;
    logic       button_side_pressed;
    logic [1:0] command;
    logic       lamp_select;
  } item_t;

  typedef struct packed {
    logic       relay_top;
    logic       relay_side;
    logic       auto_led_top;
    logic       auto_led_side;
    logic       occupied;
    logic       absence_check_running;
  } result_t;

  typedef struct packed {
    logic [7:0] absence_timeout_s;
    logic [7:0] ticks_per_second;
    logic [7:0] motion_grace_s;
    logic [7:0] debounce_ticks;
    logic       dark;
  } cfg_t;

  typedef struct packed {
    logic       someone_present;
    logic       absence_running;
    logic [7:0] tick_count;
    logic [7:0] second_count;
    logic       door_last;
    logic       auto_top;
    logic       auto_side;
    logic       key_top_open;
    logic       key_side_open;
    logic       remote_top_on;
    logic       remote_side_on;
    logic [7:0] debounce_left;
    logic       lamp_top;
    logic       lamp_side;
  } state_t;

  localparam cfg_t CfgReset = '{
    absence_timeout_s: 8'd30,
    ticks_per_second:  8'd42,
    motion_grace_s:    8'd5,
    debounce_ticks:    8'd25,
    dark:              1'b1
  };

  localparam state_t StateReset = '{
    someone_present: 1'b0,
    absence_running: 1'b0,
    tick_count:      8'd0,
    second_count:    8'd0,
    door_last:       1'b1,
    auto_top:        1'b1,
    auto_side:       1'b1,
    key_top_open:    1'b1,
    key_side_open:   1'b1,
    remote_top_on:   1'b0,
    remote_side_on:  1'b0,
    debounce_left:   8'd0,
    lamp_top:        1'b0,
    lamp_side:       1'b0
  };

  function automatic state_t timer_halt(state_t s);
    state_t r;
    r = s;
    r.absence_running = 1'b0;
    r.tick_count      = 8'd0;
    r.second_count    = 8'd0;
    return r;
  endfunction

  function automatic state_t light_auto(state_t s, logic dark);
    state_t r;
    r = s;
    if (dark) begin
      if (r.auto_top) r.lamp_top = 1'b1;
      if (r.auto_side) r.lamp_side = 1'b1;
    end
    return r;
  endfunction

  // toggle auto mode of one lamp; manual lamps follow their wall key
  function automatic state_t flip_auto(state_t s, logic side, logic dark);
    state_t r;
    r = s;
    if (side) r.auto_side = ~r.auto_side;
    else      r.auto_top  = ~r.auto_top;
    if (r.someone_present && dark) r = light_auto(r, dark);
    if (!r.auto_top) r.lamp_top = ~r.key_top_open;
    if (!r.auto_side) r.lamp_side = ~r.key_side_open;
    return r;
  endfunction

endpackage

/* rtl/olc_core.sv */
// ----------------------------------------------------------------------------
// olc_core: next-state logic
// Applies one request to the controller state in a single combinational pass.
// ----------------------------------------------------------------------------
module olc_core (
  input  olc_pkg::state_t state_i,
  input  olc_pkg::cfg_t   cfg_i,
  input  olc_pkg::item_t  item_i,
  output olc_pkg::state_t state_o
);
  import olc_pkg::*;

  state_t s;
  logic   auto_sel;

  always_comb begin
    s        = state_i;
    auto_sel = item_i.lamp_select ? state_i.auto_side : state_i.auto_top;
    case (op_e'(item_i.op))
      OP_TICK: begin
        if (s.debounce_left != 8'd0) s.debounce_left = s.debounce_left - 8'd1;
        if (s.absence_running) begin
          s.tick_count = s.tick_count + 8'd1;
          if (s.tick_count == cfg_i.ticks_per_second) begin
            s.tick_count   = 8'd0;
            s.second_count = s.second_count + 8'd1;
            if ((s.second_count > cfg_i.motion_grace_s) && item_i.motion_level) begin
              s = timer_halt(s);
            end else if (s.second_count == cfg_i.absence_timeout_s) begin
              s = timer_halt(s);
              if (!item_i.motion_level) begin
                s.someone_present = 1'b0;
                if (s.auto_top && !s.remote_top_on) s.lamp_top = 1'b0;
                if (s.auto_side && !s.remote_side_on) s.lamp_side = 1'b0;
              end
            end
          end
        end
      end
      OP_DOOR: begin
        if (item_i.door_level != s.door_last) begin
          s.door_last = item_i.door_level;
          if (item_i.door_level) begin
            if (!item_i.motion_level) begin
              s = timer_halt(s);
              s.someone_present = 1'b1;
              s = light_auto(s, cfg_i.dark);
            end else begin
              s.absence_running = 1'b1;
            end
          end else if (!item_i.motion_level) begin
            // keep counts of a timer that is already running
            s.absence_running = 1'b1;
          end
        end
      end
      OP_MOTION: begin
        if (item_i.motion_level) begin
          s.someone_present = 1'b1;
          s = timer_halt(s);
          s = light_auto(s, cfg_i.dark);
        end
      end
      OP_POLL: begin
        if (s.key_top_open) begin
          if (!item_i.key_top_open) begin
            s.key_top_open = 1'b0;
            s.lamp_top     = 1'b1;
          end
        end else if (item_i.key_top_open) begin
          s.key_top_open  = 1'b1;
          s.lamp_top      = 1'b0;
          s.remote_top_on = 1'b0;
        end
        if (s.key_side_open) begin
          if (!item_i.key_side_open) begin
            s.key_side_open = 1'b0;
            s.lamp_side     = 1'b1;
          end
        end else if (item_i.key_side_open) begin
          s.key_side_open  = 1'b1;
          s.lamp_side      = 1'b0;
          s.remote_side_on = 1'b0;
        end
        // top button first; side sees the debounce it may have started
        if (item_i.button_top_pressed && (s.debounce_left == 8'd0)) begin
          s = flip_auto(s, 1'b0, cfg_i.dark);
          s.debounce_left = cfg_i.debounce_ticks;
        end
        if (item_i.button_side_pressed && (s.debounce_left == 8'd0)) begin
          s = flip_auto(s, 1'b1, cfg_i.dark);
          s.debounce_left = cfg_i.debounce_ticks;
        end
      end
      OP_REMOTE: begin
        case (cmd_e'(item_i.command))
          CMD_ON: begin
            if (item_i.lamp_select) begin
              s.lamp_side      = 1'b1;
              s.remote_side_on = 1'b1;
            end else begin
              s.lamp_top      = 1'b1;
              s.remote_top_on = 1'b1;
            end
          end
          CMD_OFF: begin
            if (item_i.lamp_select) begin
              s.lamp_side      = 1'b0;
              s.remote_side_on = 1'b0;
            end else begin
              s.lamp_top      = 1'b0;
              s.remote_top_on = 1'b0;
            end
          end
          CMD_AUTO_EN: begin
            if (!auto_sel) s = flip_auto(s, item_i.lamp_select, cfg_i.dark);
          end
          CMD_AUTO_DIS: begin
            if (auto_sel) s = flip_auto(s, item_i.lamp_select, cfg_i.dark);
          end
          default: begin
            s = state_i;
          end
        endcase
      end
      default: begin
        s = state_i;
      end
    endcase
  end

  assign state_o = s;

endmodule

/* rtl/occupancy_light_controller.sv */
// ----------------------------------------------------------------------------
// occupancy_light_controller: room occupancy and two-lamp relay control
// Takes tick, door, motion, poll and remote requests and reports the lamp,
// auto-mode, occupancy and absence-timer flags after each request.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  request  | in_valid_i, in_stall_o, op_i ...     | in
//  result   | out_valid_o, out_stall_i, relay_*_o  | out
//  config   | cfg_valid_i, cfg_ready_o, cfg_*_i    | in
//
// One request per cycle while in_stall_o is low.
// State updates in the accepting cycle; the result goes to an output register
// backed by one skid slot, and in_stall_o rises only when the skid is full.
// Reset restores the state, config and output valid flags to their defaults;
// the result data registers are not reset. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module occupancy_light_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           op_i,
  input  logic                                 door_level_i,
  input  logic                                 motion_level_i,
  input  logic                                 key_top_open_i,
  input  logic                                 key_side_open_i,
  input  logic                                 button_top_pressed_i,
  input  logic                                 button_side_pressed_i,
  input  logic [1:0]                           command_i,
  input  logic                                 lamp_select_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 relay_top_o,
  output logic                                 relay_side_o,
  output logic                                 auto_led_top_o,
  output logic                                 auto_led_side_o,
  output logic                                 occupied_o,
  output logic                                 absence_check_running_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [olc_pkg::RegIdxW-1:0]          cfg_index_i,
  input  logic [olc_pkg::CfgDataW-1:0]         cfg_data_i
);
  import olc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item;
  result_t res;
  result_t head_q, head_d, skid_q, skid_d;
  logic    head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;
  logic    push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ABSENCE_TIMEOUT: cfg_q.absence_timeout_s <= cfg_data_i;
        REG_TICKS_PER_SEC:   cfg_q.ticks_per_second  <= cfg_data_i;
        REG_MOTION_GRACE:    cfg_q.motion_grace_s    <= cfg_data_i;
        REG_DEBOUNCE:        cfg_q.debounce_ticks    <= cfg_data_i;
        REG_DARK:            cfg_q.dark              <= cfg_data_i[0];
        default:             cfg_q                   <= cfg_q;
      endcase
    end
  end

  assign item = '{
    op:                  op_i,
    door_level:          door_level_i,
    motion_level:        motion_level_i,
    key_top_open:        key_top_open_i,
    key_side_open:       key_side_open_i,
    button_top_pressed:  button_top_pressed_i,
    button_side_pressed: button_side_pressed_i,
    command:             command_i,
    lamp_select:         lamp_select_i
  };

  olc_core u_core (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (item),
    .state_o (state_d)
  );

  assign in_stall_o = skid_valid_q;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = head_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (push) begin
      state_q <= state_d;
    end
  end

  assign res = '{
    relay_top:             state_d.lamp_top,
    relay_side:            state_d.lamp_side,
    auto_led_top:          state_d.auto_top,
    auto_led_side:         state_d.auto_side,
    occupied:              state_d.someone_present,
    absence_check_running: state_d.absence_running
  };

  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    // advance the skid into the head when the head is taken
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = 1'b0;
      end
    end
    if (push) begin
      if (!head_valid_d) begin
        head_d       = res;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o             = head_valid_q;
  assign relay_top_o             = head_q.relay_top;
  assign relay_side_o            = head_q.relay_side;
  assign auto_led_top_o          = head_q.auto_led_top;
  assign auto_led_side_o         = head_q.auto_led_side;
  assign occupied_o              = head_q.occupied;
  assign absence_check_running_o = head_q.absence_check_running;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for occupancy_light_controller
// Drives tick, door, motion, poll and remote requests through the request
// channel with random gaps and result stalls, steps an in-bench model of the
// room for each accepted request and compares every result flag. Several
// register settings are loaded between drained phases, including extremes.
// ----------------------------------------------------------------------------
module testbench;
  import olc_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i            = 1'b0;
  logic                in_stall_o;
  logic [2:0]          op_i                  = '0;
  logic                door_level_i          = 1'b1;
  logic                motion_level_i        = 1'b0;
  logic                key_top_open_i        = 1'b1;
  logic                key_side_open_i       = 1'b1;
  logic                button_top_pressed_i  = 1'b0;
  logic                button_side_pressed_i = 1'b0;
  logic [1:0]          command_i             = '0;
  logic                lamp_select_i         = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i           = 1'b0;
  logic                relay_top_o;
  logic                relay_side_o;
  logic                auto_led_top_o;
  logic                auto_led_side_o;
  logic                occupied_o;
  logic                absence_check_running_o;
  logic                cfg_valid_i           = 1'b0;
  logic                cfg_ready_o;
  logic [RegIdxW-1:0]  cfg_index_i           = '0;
  logic [CfgDataW-1:0] cfg_data_i            = '0;

  occupancy_light_controller uut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .op_i                    (op_i),
    .door_level_i            (door_level_i),
    .motion_level_i          (motion_level_i),
    .key_top_open_i          (key_top_open_i),
    .key_side_open_i         (key_side_open_i),
    .button_top_pressed_i    (button_top_pressed_i),
    .button_side_pressed_i   (button_side_pressed_i),
    .command_i               (command_i),
    .lamp_select_i           (lamp_select_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .relay_top_o             (relay_top_o),
    .relay_side_o            (relay_side_o),
    .auto_led_top_o          (auto_led_top_o),
    .auto_led_side_o         (auto_led_side_o),
    .occupied_o              (occupied_o),
    .absence_check_running_o (absence_check_running_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  // room model: registers
  logic [7:0] cfg_timeout  = 8'd30;
  logic [7:0] cfg_tps      = 8'd42;
  logic [7:0] cfg_grace    = 8'd5;
  logic [7:0] cfg_debounce = 8'd25;
  logic       cfg_dark     = 1'b1;

  // room model: state
  logic       occ          = 1'b0;
  logic       timer_on     = 1'b0;
  logic [7:0] sub_ticks    = 8'd0;
  logic [7:0] secs         = 8'd0;
  logic       door_prev    = 1'b1;
  logic       auto_t       = 1'b1;
  logic       auto_s       = 1'b1;
  logic       key_t_open   = 1'b1;
  logic       key_s_open   = 1'b1;
  logic       remote_t     = 1'b0;
  logic       remote_s     = 1'b0;
  logic [7:0] debounce_cnt = 8'd0;
  logic       lamp_t       = 1'b0;
  logic       lamp_s       = 1'b0;

  item_t   request_q[$];
  result_t lamp_status_q[$];
  item_t   cur_req;
  result_t want, next_status;

  logic        send_busy    = 1'b0;
  logic        req_accepted = 1'b0;
  logic        res_taken    = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned calm_left    = 0;

  logic gen_door   = 1'b1;
  logic gen_motion = 1'b0;
  logic gen_key_t  = 1'b1;
  logic gen_key_s  = 1'b1;

  int unsigned errors         = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen   = 0;
  int unsigned expiries       = 0;
  int unsigned grace_cancels  = 0;
  int unsigned settings_used  = 1;

  function automatic int unsigned draw_wait();
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    // now and then run a stretch without any idling
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic halt_absence_timer();
    timer_on  = 1'b0;
    sub_ticks = 8'd0;
    secs      = 8'd0;
  endtask

  task automatic auto_lamps_on();
    if (cfg_dark) begin
      if (auto_t) lamp_t = 1'b1;
      if (auto_s) lamp_s = 1'b1;
    end
  endtask

  task automatic toggle_auto_mode(input logic side);
    if (side) auto_s = ~auto_s;
    else auto_t = ~auto_t;
    if (occ && cfg_dark) auto_lamps_on();
    // manual lamps follow their wall key
    if (!auto_t) lamp_t = ~key_t_open;
    if (!auto_s) lamp_s = ~key_s_open;
  endtask

  task automatic apply_tick(input logic motion);
    if (debounce_cnt != 0) debounce_cnt--;
    if (timer_on) begin
      sub_ticks++;
      if (sub_ticks == cfg_tps) begin
        sub_ticks = 8'd0;
        secs++;
        if (secs > cfg_grace && motion) begin
          halt_absence_timer();
          grace_cancels++;
        end else if (secs == cfg_timeout) begin
          halt_absence_timer();
          if (!motion) begin
            occ = 1'b0;
            if (auto_t && !remote_t) lamp_t = 1'b0;
            if (auto_s && !remote_s) lamp_s = 1'b0;
            expiries++;
          end
        end
      end
    end
  endtask

  task automatic apply_door(input logic door, input logic motion);
    if (door != door_prev) begin
      door_prev = door;
      if (door) begin
        if (!motion) begin
          halt_absence_timer();
          occ = 1'b1;
          auto_lamps_on();
        end else begin
          timer_on = 1'b1;
        end
      end else if (!motion && !timer_on) begin
        timer_on = 1'b1;
      end
    end
  endtask

  task automatic apply_poll(input item_t it);
    if (key_t_open) begin
      if (!it.key_top_open) begin
        key_t_open = 1'b0;
        lamp_t     = 1'b1;
      end
    end else if (it.key_top_open) begin
      key_t_open = 1'b1;
      lamp_t     = 1'b0;
      remote_t   = 1'b0;
    end
    if (key_s_open) begin
      if (!it.key_side_open) begin
        key_s_open = 1'b0;
        lamp_s     = 1'b1;
      end
    end else if (it.key_side_open) begin
      key_s_open = 1'b1;
      lamp_s     = 1'b0;
      remote_s   = 1'b0;
    end
    // top button goes first; it blocks the side one unless the debounce setting is zero
    if (it.button_top_pressed && debounce_cnt == 0) begin
      toggle_auto_mode(1'b0);
      debounce_cnt = cfg_debounce;
    end
    if (it.button_side_pressed && debounce_cnt == 0) begin
      toggle_auto_mode(1'b1);
      debounce_cnt = cfg_debounce;
    end
  endtask

  task automatic apply_remote(input logic [1:0] cmd, input logic side);
    logic mode_on;
    mode_on = side ? auto_s : auto_t;
    case (cmd)
      CMD_ON: begin
        if (side) begin
          lamp_s   = 1'b1;
          remote_s = 1'b1;
        end else begin
          lamp_t   = 1'b1;
          remote_t = 1'b1;
        end
      end
      CMD_OFF: begin
        if (side) begin
          lamp_s   = 1'b0;
          remote_s = 1'b0;
        end else begin
          lamp_t   = 1'b0;
          remote_t = 1'b0;
        end
      end
      CMD_AUTO_EN: begin
        if (!mode_on) toggle_auto_mode(side);
      end
      default: begin
        if (mode_on) toggle_auto_mode(side);
      end
    endcase
  endtask

  task automatic advance_room(input item_t it);
    case (it.op)
      OP_TICK:   apply_tick(it.motion_level);
      OP_DOOR:   apply_door(it.door_level, it.motion_level);
      OP_MOTION: begin
        if (it.motion_level) begin
          occ = 1'b1;
          halt_absence_timer();
          auto_lamps_on();
        end
      end
      OP_POLL:   apply_poll(it);
      OP_REMOTE: apply_remote(it.command, it.lamp_select);
      default: ;
    endcase
  endtask

  task automatic check_flag(input string name, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_accepted) begin
        req_accepted = 1'b0;
        send_busy    = 1'b0;
        send_gap     = draw_wait();
      end
      if (!send_busy) begin
        if (send_gap != 0) send_gap--;
        else if (request_q.size() != 0) begin
          cur_req   = request_q.pop_front();
          send_busy = 1'b1;
        end
      end
      in_valid_i            <= send_busy;
      op_i                  <= cur_req.op;
      door_level_i          <= cur_req.door_level;
      motion_level_i        <= cur_req.motion_level;
      key_top_open_i        <= cur_req.key_top_open;
      key_side_open_i       <= cur_req.key_side_open;
      button_top_pressed_i  <= cur_req.button_top_pressed;
      button_side_pressed_i <= cur_req.button_side_pressed;
      command_i             <= cur_req.command;
      lamp_select_i         <= cur_req.lamp_select;
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken  = 1'b0;
        stall_left = draw_wait();
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // monitor: check results first, then step the model for a new request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        res_taken = 1'b1;
        results_seen++;
        if (lamp_status_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %b", $time,
                   {relay_top_o, relay_side_o, auto_led_top_o, auto_led_side_o,
                    occupied_o, absence_check_running_o});
          errors++;
        end else begin
          want = lamp_status_q.pop_front();
          check_flag("relay_top", want.relay_top, relay_top_o);
          check_flag("relay_side", want.relay_side, relay_side_o);
          check_flag("auto_led_top", want.auto_led_top, auto_led_top_o);
          check_flag("auto_led_side", want.auto_led_side, auto_led_side_o);
          check_flag("occupied", want.occupied, occupied_o);
          check_flag("absence_check_running", want.absence_check_running,
                     absence_check_running_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        advance_room(cur_req);
        next_status.relay_top             = lamp_t;
        next_status.relay_side            = lamp_s;
        next_status.auto_led_top          = auto_t;
        next_status.auto_led_side         = auto_s;
        next_status.occupied              = occ;
        next_status.absence_check_running = timer_on;
        lamp_status_q.push_back(next_status);
        req_accepted = 1'b1;
        requests_taken++;
      end
    end
  end

  function automatic item_t make_req(input logic [2:0] code, input logic door,
                                     input logic motion);
    logic [31:0] r;
    item_t it;
    r = $urandom;
    it = item_t'(r[$bits(item_t)-1:0]);
    it.op           = code;
    it.door_level   = door;
    it.motion_level = motion;
    return it;
  endfunction

  task automatic queue_req(input item_t it);
    request_q.push_back(it);
    if (it.op == OP_DOOR) gen_door = it.door_level;
  endtask

  // hold until the block has nothing in flight, then let it settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || send_busy || lamp_status_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // call at a falling edge; leaves valid high, the caller drops it
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_ABSENCE_TIMEOUT: cfg_timeout  = data;
      REG_TICKS_PER_SEC:   cfg_tps      = data;
      REG_MOTION_GRACE:    cfg_grace    = data;
      REG_DEBOUNCE:        cfg_debounce = data;
      REG_DARK:            cfg_dark     = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic add_directed();
    item_t it;
    queue_req(make_req(3'(OP_REMOTE) + 3'd1, 1'b0, 1'b1));  // unused op
    queue_req(make_req(OP_TICK, 1'b0, 1'b0));               // timer stopped
    queue_req(make_req(OP_DOOR, 1'b1, 1'b0));               // no door change
    queue_req(make_req(OP_MOTION, 1'b0, 1'b0));             // spurious pulse
    queue_req(make_req(OP_DOOR, 1'b0, 1'b0));               // start timer
    queue_req(make_req(OP_DOOR, 1'b0, 1'b0));
    queue_req(make_req(OP_TICK, 1'b0, 1'b0));
    queue_req(make_req(OP_TICK, 1'b0, 1'b0));
    queue_req(make_req(OP_DOOR, 1'b1, 1'b1));               // restart keeps counts
    queue_req(make_req(OP_MOTION, 1'b1, 1'b1));
    it = make_req(OP_POLL, 1'b1, 1'b1);
    {it.key_top_open, it.key_side_open} = 2'b00;
    {it.button_top_pressed, it.button_side_pressed} = 2'b00;
    queue_req(it);
    it.button_top_pressed  = 1'b1;                          // both held
    it.button_side_pressed = 1'b1;
    queue_req(it);
    {it.key_top_open, it.key_side_open} = 2'b11;
    {it.button_top_pressed, it.button_side_pressed} = 2'b00;
    queue_req(it);
    it = make_req(OP_REMOTE, 1'b1, 1'b1);
    it.command = CMD_ON;       it.lamp_select = 1'b0; queue_req(it);
    it.command = CMD_ON;       it.lamp_select = 1'b1; queue_req(it);
    it.command = CMD_OFF;      it.lamp_select = 1'b1; queue_req(it);
    it.command = CMD_AUTO_EN;  it.lamp_select = 1'b0; queue_req(it);
    it.command = CMD_AUTO_DIS; it.lamp_select = 1'b1; queue_req(it);
    it.command = CMD_AUTO_EN;  it.lamp_select = 1'b1; queue_req(it);
    it.command = CMD_AUTO_EN;  it.lamp_select = 1'b0; queue_req(it);
    it.command = CMD_OFF;      it.lamp_select = 1'b0; queue_req(it);
    queue_req(make_req(OP_DOOR, 1'b0, 1'b1));
    queue_req(make_req(OP_DOOR, 1'b1, 1'b0));               // entry
    queue_req(make_req(OP_TICK, 1'b1, 1'b1));
    queue_req(make_req(3'(OP_REMOTE) + 3'd2, 1'b1, 1'b0));
  endtask

  task automatic add_random(input int count, input int burst_max);
    item_t it;
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 7) == 0) gen_motion = ~gen_motion;
      it = make_req(OP_TICK, gen_door, gen_motion);
      if ($urandom_range(0, 7) == 0) it.motion_level = ~gen_motion;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        it.op = OP_TICK;
      end else if (pick < 54) begin
        it.op = OP_DOOR;
        it.door_level = ($urandom_range(0, 4) != 0) ? ~gen_door : gen_door;
      end else if (pick < 64) begin
        it.op = OP_MOTION;
      end else if (pick < 80) begin
        it.op = OP_POLL;
        if ($urandom_range(0, 4) == 0) gen_key_t = ~gen_key_t;
        if ($urandom_range(0, 4) == 0) gen_key_s = ~gen_key_s;
        it.key_top_open        = gen_key_t;
        it.key_side_open       = gen_key_s;
        it.button_top_pressed  = ($urandom_range(0, 2) == 0);
        it.button_side_pressed = ($urandom_range(0, 2) == 0);
      end else if (pick < 96) begin
        it.op = OP_REMOTE;
      end else begin
        it.op = 3'(OP_REMOTE) + 3'($urandom_range(1, 3));
      end
      queue_req(it);
      // a run of ticks, up to burst_max long, that may reach grace and timeout
      if (it.op == OP_TICK && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, burst_max))
          queue_req(make_req(OP_TICK, gen_door, gen_motion));
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] tmo, input logic [7:0] tps,
                           input logic [7:0] grace, input logic [7:0] deb,
                           input logic dk, input int count, input bit long_run);
    int burst;
    wait_idle();
    write_reg(REG_ABSENCE_TIMEOUT, tmo);
    write_reg(REG_TICKS_PER_SEC, tps);
    write_reg(REG_MOTION_GRACE, grace);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DARK, {7'($urandom), dk});
    write_reg(3'(REG_DARK) + 3'($urandom_range(1, 3)), 8'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
    if (long_run) begin
      // enter, leave quietly, then tick through a wrapped count
      if (gen_door) queue_req(make_req(OP_DOOR, 1'b0, 1'b1));
      queue_req(make_req(OP_DOOR, 1'b1, 1'b0));
      queue_req(make_req(OP_DOOR, 1'b0, 1'b0));
      repeat (258) queue_req(make_req(OP_TICK, 1'b0, 1'b0));
      gen_motion = 1'b0;
    end
    burst = (tmo == 0 || tps == 0) ? 40 : int'(tmo) * int'(tps) + 2;
    if (burst > 40) burst = 40;
    add_random(count, burst);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    run_phase(8'd2,   8'd1,   8'd0,   8'd0,   1'b1, 30, 1'b0);
    run_phase(8'd3,   8'd2,   8'd1,   8'd2,   1'b0, 30, 1'b0);
    run_phase(8'd0,   8'd1,   8'd255, 8'd1,   1'b1, 10, 1'b1);
    run_phase(8'd1,   8'd0,   8'd0,   8'd255, 1'b1, 10, 1'b1);
    run_phase(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 20, 1'b0);
    run_phase(8'd4,   8'd3,   8'd2,   8'd5,   1'b1, 50, 1'b0);
    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d requests and checked %0d results over %0d register settings.",
             requests_taken, results_seen, settings_used);
    $display("Room went empty on timeout %0d times; motion cancelled the timer %0d times.",
             expiries, grace_cancels);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/olc_pkg.sv
rtl/olc_core.sv
rtl/occupancy_light_controller.sv
verif/testbench.sv
